### src/mrtf_pkg.sv
// Package for the multi-rate tick flag unit: field widths, rate periods,
// reset stamps and flag bit positions. No dependencies.
package mrtf_pkg;

   localparam int unsigned FastChannels = 6;

   localparam int unsigned NowWidth    = 16;
   localparam int unsigned SpeedWidth  = 15;
   localparam int unsigned FlagWidth   = 8;
   localparam int unsigned ChangeWidth = 16;
   localparam int unsigned TenthsWidth = 32;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned StampWidth  = 8;
   localparam int unsigned DelayWidth  = 8;

   localparam int unsigned FlagTenHz     = 5;
   localparam int unsigned FlagQuarterHz = 6;
   localparam int unsigned FlagOneHz     = 7;

   typedef logic [StampWidth-1:0] stamp_type;
   typedef stamp_type [FastChannels-1:0] fast_stamps_type;

   localparam fast_stamps_type FastPeriod = {
      8'd100, 8'd66, 8'd33, 8'd20, 8'd5, 8'd1
   };
   localparam fast_stamps_type FastReset = {
      8'd3, 8'd2, 8'd1, 8'd0, 8'd0, 8'd0
   };

   localparam logic [NowWidth-1:0] QuarterPeriod = 16'd250;
   localparam logic [NowWidth-1:0] SecondPeriod  = 16'd1000;
   localparam logic [NowWidth-1:0] QuarterReset  = 16'd4;
   localparam logic [NowWidth-1:0] SecondReset   = 16'd6;

   localparam logic [CountWidth-1:0] RunSecondsMax = 8'd255;

   localparam logic signed [19:0] ChangeMax = 20'sd32767;
   localparam logic signed [19:0] ChangeMin = -20'sd32768;

endpackage

### src/mrtf_req_if.sv
// Request channel of the multi-rate tick flag unit: one millisecond sample.
// Depends on mrtf_pkg.
interface mrtf_req_if;
   logic                              valid;
   logic                              ready;
   logic [mrtf_pkg::NowWidth-1:0]     now_ms;
   logic [mrtf_pkg::SpeedWidth-1:0]   engine_speed;
   logic                              engine_running;
   logic                              init_done;

   modport source(output valid, now_ms, engine_speed, engine_running, init_done,
                  input ready);
   modport sink(input valid, now_ms, engine_speed, engine_running, init_done,
                output ready);
endinterface

### src/mrtf_rsp_if.sv
// Result channel of the multi-rate tick flag unit: flags and counters.
// Depends on mrtf_pkg.
interface mrtf_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [mrtf_pkg::FlagWidth-1:0]        tick_flags;
   logic signed [mrtf_pkg::ChangeWidth-1:0] speed_change;
   logic [mrtf_pkg::TenthsWidth-1:0]      run_tenths;
   logic [mrtf_pkg::CountWidth-1:0]       run_seconds;
   logic [mrtf_pkg::CountWidth-1:0]       seconds_count;
   logic                                  prime_injectors;

   modport source(output valid, tick_flags, speed_change, run_tenths, run_seconds,
                  seconds_count, prime_injectors, input ready);
   modport sink(input valid, tick_flags, speed_change, run_tenths, run_seconds,
                seconds_count, prime_injectors, output ready);
endinterface

### src/mrtf_csr_if.sv
// Configuration write channel of the multi-rate tick flag unit (priming delay).
// Depends on mrtf_pkg.
interface mrtf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mrtf_pkg::DelayWidth-1:0]   data;

   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

### src/multi_rate_tick_flags_unit.sv
// Top level of the multi-rate tick flag unit: rate flags, speed change and run counters.
// Depends on mrtf_pkg, mrtf_req_if, mrtf_rsp_if and mrtf_csr_if.
//
// Each request on req_if carries one sample of the free-running millisecond count,
// the engine speed and two status bits. For every request exactly one result
// leaves on rsp_if, in order, with the eight rate flags and the current counters.
// A request is taken into an input register; once the result register is free,
// the flag and counter logic loads it from the input register and updates the
// timing state. One request is accepted in every cycle while results are taken.
// When the receiver stalls, the result register holds, the input register fills,
// and req_if.ready drops until the result is taken.
// The csr_if channel writes the priming delay in tenths of a second; it is
// always ready and should be written only while no request is in flight.
// A synchronous reset empties both registers and returns every stamp and
// counter to its starting value, with the priming delay at zero.
module multi_rate_tick_flags_unit (
   input logic clock,
   input logic reset,
   mrtf_req_if.sink   req_if,
   mrtf_rsp_if.source rsp_if,
   mrtf_csr_if.sink   csr_if
);

   logic                                  in_valid_ff;
   logic [mrtf_pkg::NowWidth-1:0]         now_ms_ff;
   logic [mrtf_pkg::SpeedWidth-1:0]       speed_ff;
   logic                                  running_ff;
   logic                                  init_ff;
   logic                                  advance;
   logic                                  take_req;

   logic [mrtf_pkg::DelayWidth-1:0]       priming_delay_ff;
   mrtf_pkg::fast_stamps_type             fast_stamps_ff, fast_stamps_in;
   logic [mrtf_pkg::NowWidth-1:0]         quarter_stamp_ff, quarter_stamp_in;
   logic [mrtf_pkg::NowWidth-1:0]         second_stamp_ff, second_stamp_in;
   logic [mrtf_pkg::SpeedWidth-1:0]       last_speed_ff, last_speed_in;
   logic signed [mrtf_pkg::ChangeWidth-1:0] speed_change_ff, speed_change_in;
   logic [mrtf_pkg::TenthsWidth-1:0]      run_tenths_ff, run_tenths_in;
   logic [mrtf_pkg::NowWidth-1:0]         tenths_start_ff, tenths_start_in;
   logic [mrtf_pkg::CountWidth-1:0]       run_seconds_ff, run_seconds_in;
   logic [mrtf_pkg::CountWidth-1:0]       seconds_ff, seconds_in;
   logic                                  primed_ff, primed_in;

   logic                                  rsp_valid_ff;
   logic [mrtf_pkg::FlagWidth-1:0]        flags_ff, flags_in;
   logic                                  prime_ff, prime_in;

   logic [mrtf_pkg::StampWidth-1:0]       low_byte;
   logic [mrtf_pkg::StampWidth-1:0]       gap;
   logic [mrtf_pkg::NowWidth-1:0]         quarter_gap;
   logic [mrtf_pkg::NowWidth-1:0]         second_gap;
   logic signed [mrtf_pkg::SpeedWidth+1:0] diff;
   logic signed [19:0]                    diff_x10;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign take_req     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (take_req) begin
         now_ms_ff  <= req_if.now_ms;
         speed_ff   <= req_if.engine_speed;
         running_ff <= req_if.engine_running;
         init_ff    <= req_if.init_done;
      end
   end

   always_comb begin
      fast_stamps_in   = fast_stamps_ff;
      quarter_stamp_in = quarter_stamp_ff;
      second_stamp_in  = second_stamp_ff;
      last_speed_in    = last_speed_ff;
      speed_change_in  = speed_change_ff;
      run_tenths_in    = run_tenths_ff;
      tenths_start_in  = tenths_start_ff;
      run_seconds_in   = run_seconds_ff;
      seconds_in       = seconds_ff;
      primed_in        = primed_ff;
      flags_in         = '0;
      prime_in         = 1'b0;
      gap              = '0;

      low_byte = now_ms_ff[mrtf_pkg::StampWidth-1:0];
      for (int i = 0; i < mrtf_pkg::FastChannels; i++) begin
         gap = low_byte - fast_stamps_ff[i];
         if (gap >= mrtf_pkg::FastPeriod[i]) begin
            fast_stamps_in[i] = low_byte;
            flags_in[i]       = 1'b1;
         end
      end

      diff     = $signed({2'b00, speed_ff}) - $signed({2'b00, last_speed_ff});
      diff_x10 = ($signed(20'(diff)) <<< 3) + ($signed(20'(diff)) <<< 1);

      if (flags_in[mrtf_pkg::FlagTenHz]) begin
         if (diff_x10 > mrtf_pkg::ChangeMax) begin
            speed_change_in = mrtf_pkg::ChangeMax[mrtf_pkg::ChangeWidth-1:0];
         end else if (diff_x10 < mrtf_pkg::ChangeMin) begin
            speed_change_in = mrtf_pkg::ChangeMin[mrtf_pkg::ChangeWidth-1:0];
         end else begin
            speed_change_in = diff_x10[mrtf_pkg::ChangeWidth-1:0];
         end
         last_speed_in = speed_ff;
         run_tenths_in = running_ff ? run_tenths_ff + 1'b1 : '0;
         if (!primed_ff && tenths_start_ff >= {8'd0, priming_delay_ff} &&
             speed_ff == '0 && init_ff) begin
            prime_in  = 1'b1;
            primed_in = 1'b1;
         end
         tenths_start_in = tenths_start_ff + 1'b1;
      end

      quarter_gap = now_ms_ff - quarter_stamp_ff;
      if (quarter_gap >= mrtf_pkg::QuarterPeriod) begin
         quarter_stamp_in                 = quarter_stamp_ff + mrtf_pkg::QuarterPeriod;
         flags_in[mrtf_pkg::FlagQuarterHz] = 1'b1;
      end

      second_gap = now_ms_ff - second_stamp_ff;
      if (second_gap >= mrtf_pkg::SecondPeriod) begin
         second_stamp_in              = second_stamp_ff + mrtf_pkg::SecondPeriod;
         flags_in[mrtf_pkg::FlagOneHz] = 1'b1;
         if (running_ff && run_seconds_ff != mrtf_pkg::RunSecondsMax) begin
            run_seconds_in = run_seconds_ff + 1'b1;
         end
         seconds_in = seconds_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priming_delay_ff <= '0;
         fast_stamps_ff   <= mrtf_pkg::FastReset;
         quarter_stamp_ff <= mrtf_pkg::QuarterReset;
         second_stamp_ff  <= mrtf_pkg::SecondReset;
         last_speed_ff    <= '0;
         speed_change_ff  <= '0;
         run_tenths_ff    <= '0;
         tenths_start_ff  <= '0;
         run_seconds_ff   <= '0;
         seconds_ff       <= '0;
         primed_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            priming_delay_ff <= csr_if.data;
         end
         if (advance) begin
            fast_stamps_ff   <= fast_stamps_in;
            quarter_stamp_ff <= quarter_stamp_in;
            second_stamp_ff  <= second_stamp_in;
            last_speed_ff    <= last_speed_in;
            speed_change_ff  <= speed_change_in;
            run_tenths_ff    <= run_tenths_in;
            tenths_start_ff  <= tenths_start_in;
            run_seconds_ff   <= run_seconds_in;
            seconds_ff       <= seconds_in;
            primed_ff        <= primed_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         flags_ff <= flags_in;
         prime_ff <= prime_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.tick_flags      = flags_ff;
   assign rsp_if.speed_change    = speed_change_ff;
   assign rsp_if.run_tenths      = run_tenths_ff;
   assign rsp_if.run_seconds     = run_seconds_ff;
   assign rsp_if.seconds_count   = seconds_ff;
   assign rsp_if.prime_injectors = prime_ff;

   a_prime_on_tenth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && prime_ff) |-> flags_ff[mrtf_pkg::FlagTenHz])
      else $error("priming request without a 10 Hz tick");

   a_prime_latched: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && prime_ff) |-> primed_ff)
      else $error("priming request shown but primed flag not set");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not valid after a request moved on");

endmodule

### sim/testbench.sv
// Self-checking testbench for multi_rate_tick_flags_unit: random and directed millisecond
// samples are checked against a built-in predictor of the rate flags and counters.
// Depends on mrtf_pkg, mrtf_req_if, mrtf_rsp_if, mrtf_csr_if and the unit itself.
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic [mrtf_pkg::NowWidth-1:0]   now_ms;
      logic [mrtf_pkg::SpeedWidth-1:0] engine_speed;
      logic                            engine_running;
      logic                            init_done;
   } ms_sample_type;

   typedef struct packed {
      logic [mrtf_pkg::FlagWidth-1:0]          tick_flags;
      logic signed [mrtf_pkg::ChangeWidth-1:0] speed_change;
      logic [mrtf_pkg::TenthsWidth-1:0]        run_tenths;
      logic [mrtf_pkg::CountWidth-1:0]         run_seconds;
      logic [mrtf_pkg::CountWidth-1:0]         seconds_count;
      logic                                    prime_injectors;
   } tick_result_type;

   localparam int unsigned LongHold = 400;

   logic clock = 1'b0;
   logic reset;

   mrtf_req_if req_if();
   mrtf_rsp_if rsp_if();
   mrtf_csr_if csr_if();

   multi_rate_tick_flags_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, mirroring the timing stamps and counters of the unit.
   mrtf_pkg::fast_stamps_type               fast_stamp;
   logic [mrtf_pkg::NowWidth-1:0]     quarter_stamp;
   logic [mrtf_pkg::NowWidth-1:0]     second_stamp;
   logic [mrtf_pkg::SpeedWidth-1:0]   last_speed;
   logic [mrtf_pkg::ChangeWidth-1:0]  held_change;
   logic [mrtf_pkg::TenthsWidth-1:0]  run_tenths;
   logic [15:0]                       tenths_since_reset;
   logic [mrtf_pkg::CountWidth-1:0]   run_secs;
   logic [mrtf_pkg::CountWidth-1:0]   secs;
   bit                                primed;
   logic [mrtf_pkg::DelayWidth-1:0]   prime_delay;

   ms_sample_type   pending_samples[$];
   tick_result_type expected_results[$];
   logic [mrtf_pkg::NowWidth-1:0] stim_ms;
   int           stim_speed;
   int           fault_count;
   int unsigned  results_seen;
   int unsigned  hold_mark;
   int unsigned  offer_gap;
   int unsigned  stall_left;
   logic         req_taken;

   function automatic tick_result_type predict_tick(input ms_sample_type tick_in);
      tick_result_type                 result;
      logic [mrtf_pkg::StampWidth-1:0] low_ms;
      logic [mrtf_pkg::StampWidth-1:0] since;
      logic [mrtf_pkg::NowWidth-1:0]   span;
      int                              delta;
      result = '0;
      low_ms = tick_in.now_ms[mrtf_pkg::StampWidth-1:0];
      for (int ch = 0; ch < mrtf_pkg::FastChannels; ch++) begin
         since = low_ms - fast_stamp[ch];
         if (since >= mrtf_pkg::FastPeriod[ch]) begin
            fast_stamp[ch] = low_ms;
            result.tick_flags[ch] = 1'b1;
         end
      end
      if (result.tick_flags[mrtf_pkg::FlagTenHz]) begin
         delta = (int'(tick_in.engine_speed) - int'(last_speed)) * 10;
         if (delta > mrtf_pkg::ChangeMax) begin
            delta = mrtf_pkg::ChangeMax;
         end else if (delta < mrtf_pkg::ChangeMin) begin
            delta = mrtf_pkg::ChangeMin;
         end
         held_change = mrtf_pkg::ChangeWidth'(delta);
         last_speed = tick_in.engine_speed;
         run_tenths = tick_in.engine_running ? run_tenths + 1 : '0;
         if (!primed && tenths_since_reset >= 16'(prime_delay) &&
             tick_in.engine_speed == '0 && tick_in.init_done) begin
            result.prime_injectors = 1'b1;
            primed = 1'b1;
         end
         tenths_since_reset = tenths_since_reset + 16'd1;
      end
      span = tick_in.now_ms - quarter_stamp;
      if (span >= mrtf_pkg::QuarterPeriod) begin
         quarter_stamp = quarter_stamp + mrtf_pkg::QuarterPeriod;
         result.tick_flags[mrtf_pkg::FlagQuarterHz] = 1'b1;
      end
      span = tick_in.now_ms - second_stamp;
      if (span >= mrtf_pkg::SecondPeriod) begin
         second_stamp = second_stamp + mrtf_pkg::SecondPeriod;
         result.tick_flags[mrtf_pkg::FlagOneHz] = 1'b1;
         if (tick_in.engine_running && run_secs != mrtf_pkg::RunSecondsMax) begin
            run_secs = run_secs + 1'b1;
         end
         secs = secs + 1'b1;
      end
      result.speed_change  = held_change;
      result.run_tenths    = run_tenths;
      result.run_seconds   = run_secs;
      result.seconds_count = secs;
      return result;
   endfunction

   function automatic int field_mismatch(input string field, input logic signed [32:0] want,
                                         input logic signed [32:0] got);
      if (want === got) return 0;
      $error("%s: expected %0d, actual %0d", field, want, got);
      return 1;
   endfunction

   function automatic int unsigned pick_pause();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      else if (roll < 93) return $urandom_range(1, 3);
      else return $urandom_range(8, 30);
   endfunction

   task automatic queue_sample(input int unsigned step_ms, input int speed, input bit running,
                               input bit init);
      ms_sample_type item;
      stim_ms = stim_ms + mrtf_pkg::NowWidth'(step_ms);
      stim_speed = speed;
      item.now_ms = stim_ms;
      item.engine_speed = mrtf_pkg::SpeedWidth'(speed);
      item.engine_running = running;
      item.init_done = init;
      pending_samples.push_back(item);
   endtask

   task automatic queue_mixed_samples(input int count);
      int unsigned roll;
      int unsigned step_ms;
      int          speed;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) step_ms = 1;
         else if (roll < 80) step_ms = $urandom_range(0, 4);
         else if (roll < 94) step_ms = $urandom_range(5, 120);
         else if (roll < 99) step_ms = $urandom_range(200, 1500);
         else step_ms = $urandom_range(0, 65535);
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            speed = 0;
         end else if (roll < 75) begin
            speed = stim_speed + int'($urandom_range(0, 1000)) - 500;
            if (speed < 0) speed = 0;
            if (speed > 32767) speed = 32767;
         end else if (roll < 95) begin
            speed = $urandom_range(0, 32767);
         end else begin
            speed = 32767;
         end
         queue_sample(step_ms, speed, $urandom_range(0, 4) != 0, $urandom_range(0, 99) < 85);
      end
   endtask

   // Steps of about a second, so the one-second counters run far enough to saturate and wrap.
   task automatic queue_long_run(input int count);
      int speed;
      repeat (count) begin
         speed = ($urandom_range(0, 9) < 3) ? 0 : int'($urandom_range(0, 32767));
         queue_sample($urandom_range(1000, 1300), speed, $urandom_range(0, 19) != 0,
                      $urandom_range(0, 4) != 0);
      end
   endtask

   task automatic write_priming_delay(input logic [mrtf_pkg::DelayWidth-1:0] delay_value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= delay_value;
      do @(posedge clock); while (!csr_if.ready);
      prime_delay = delay_value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_samples.size() != 0 || req_if.valid || expected_results.size() != 0);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.now_ms <= '0;
         req_if.engine_speed <= '0;
         req_if.engine_running <= 1'b0;
         req_if.init_done <= 1'b0;
         offer_gap <= 0;
      end else if (!req_if.valid || req_taken) begin
         if (offer_gap != 0) begin
            req_if.valid <= 1'b0;
            offer_gap <= offer_gap - 1;
         end else if (pending_samples.size() != 0) begin
            req_if.valid <= 1'b1;
            {req_if.now_ms, req_if.engine_speed, req_if.engine_running, req_if.init_done}
               <= pending_samples.pop_front();
            offer_gap <= pick_pause();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
         hold_mark <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (results_seen % 700 == 300 && results_seen != hold_mark) begin
         rsp_if.ready <= 1'b0;
         stall_left <= LongHold;
         hold_mark <= results_seen;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left <= pick_pause();
      end
   end

   // Results are checked before the request of the same edge is predicted.
   always @(posedge clock) begin : observe
      tick_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         results_seen <= 0;
         fault_count <= 0;
         fast_stamp = mrtf_pkg::FastReset;
         quarter_stamp = mrtf_pkg::QuarterReset;
         second_stamp = mrtf_pkg::SecondReset;
         last_speed = '0;
         held_change = '0;
         run_tenths = '0;
         tenths_since_reset = '0;
         run_secs = '0;
         secs = '0;
         primed = 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
               $error("result arrived with no request outstanding");
               fault_count <= fault_count + 1;
            end else begin
               want = expected_results.pop_front();
               fault_count <= fault_count
                  + field_mismatch("tick_flags", want.tick_flags, rsp_if.tick_flags)
                  + field_mismatch("speed_change", want.speed_change, rsp_if.speed_change)
                  + field_mismatch("run_tenths", want.run_tenths, rsp_if.run_tenths)
                  + field_mismatch("run_seconds", want.run_seconds, rsp_if.run_seconds)
                  + field_mismatch("seconds_count", want.seconds_count, rsp_if.seconds_count)
                  + field_mismatch("prime_injectors", want.prime_injectors,
                                   rsp_if.prime_injectors);
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(predict_tick({req_if.now_ms, req_if.engine_speed,
                                                     req_if.engine_running,
                                                     req_if.init_done}));
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      stim_ms = '0;
      stim_speed = 0;
      prime_delay = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_priming_delay(8'd255);
      queue_sample(0, 0, 1'b0, 1'b0);
      queue_sample(1, 0, 1'b1, 1'b1);
      queue_sample(1, 32767, 1'b1, 1'b1);
      queue_sample(4, 32767, 1'b1, 1'b1);
      queue_sample(100, 32767, 1'b1, 1'b1);
      queue_sample(100, 0, 1'b1, 1'b1);
      queue_sample(100, 100, 1'b0, 1'b1);
      queue_sample(0, 100, 1'b0, 1'b1);
      queue_sample(65535, 5, 1'b1, 1'b1);
      queue_sample(1, 5, 1'b1, 1'b0);
      queue_sample(5000, 0, 1'b1, 1'b1);
      repeat (5) queue_sample(0, 0, 1'b1, 1'b1);
      queue_sample(1000, 32767, 1'b1, 1'b1);
      queue_sample(999, 0, 1'b0, 1'b0);
      queue_sample(256, 1, 1'b1, 1'b1);
      queue_sample(33, 16384, 1'b1, 1'b1);
      queue_sample(66, 0, 1'b1, 1'b0);
      queue_sample(20, 0, 1'b1, 1'b1);
      queue_mixed_samples(500);
      wait_drained();

      write_priming_delay(mrtf_pkg::DelayWidth'($urandom_range(64, 254)));
      queue_long_run(320);
      wait_drained();

      write_priming_delay(8'd0);
      queue_mixed_samples(500);
      wait_drained();

      write_priming_delay(mrtf_pkg::DelayWidth'($urandom_range(0, 255)));
      queue_mixed_samples(500);
      wait_drained();

      repeat (4) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
      end
      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $error("simulation timed out");
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
src/mrtf_pkg.sv
src/mrtf_req_if.sv
src/mrtf_rsp_if.sv
src/mrtf_csr_if.sv
src/multi_rate_tick_flags_unit.sv
sim/testbench.sv
